/* rtl/trd_pkg.sv */
// ----------------------------------------------------------------------------
// trd_pkg
// shared types and constants of the runway dispatcher
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int SERVERS_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int CNT_W    = 8;
  localparam int TIME_W   = 16;
  localparam int ID_W     = 16;
  localparam int SRV_W    = 4;
  localparam int ACT_W    = 4;
  localparam int QLEN_W   = 14;
  localparam int TOTAL_W  = 32;
  localparam int CFG_IX_W = 3;
  localparam int CFG_W    = 16;
  localparam int ENTRY_W  = TIME_W + CNT_W;
  localparam int REC_W    = 1 + ID_W + SRV_W + TIME_W;

  localparam logic [QLEN_W-1:0] QLEN_SAT = 14'd16383;

  localparam logic [ACT_W-1:0] ACTIVE_RST    = 4'd1;
  localparam logic [CNT_W-1:0] SVC_TIME_RST  = 8'd1;
  localparam logic [ID_W-1:0]  LAND_ID_RST   = 16'd5001;
  localparam logic [ID_W-1:0]  TO_ID_RST     = 16'd1;
  localparam logic [TIME_W-1:0] MINUTE_RST   = 16'd1;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] REG_ACTIVE    = 3'd0;
  localparam logic [CFG_IX_W-1:0] REG_LAND_TIME = 3'd1;
  localparam logic [CFG_IX_W-1:0] REG_TO_TIME   = 3'd2;
  localparam logic [CFG_IX_W-1:0] REG_LAND_ID   = 3'd3;
  localparam logic [CFG_IX_W-1:0] REG_TO_ID     = 3'd4;

  // event kinds
  localparam logic [1:0] EV_LAND    = 2'd0;
  localparam logic [1:0] EV_TAKEOFF = 2'd1;
  localparam logic [1:0] EV_FREED   = 2'd2;
  localparam logic [1:0] EV_MARKER  = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_ASSIGN,
    CMD_CHECK,
    CMD_EMIT,
    CMD_MARK,
    CMD_RELEASE,
    CMD_DONE
  } cmd_t;

  typedef struct packed {
    logic scan_none;
    logic scan_last;
    logic rec_none;
    logic rec_last;
  } status_t;

endpackage

/* rtl/trd_ram.sv */
// ----------------------------------------------------------------------------
// trd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module trd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/trd_queue.sv */
// ----------------------------------------------------------------------------
// trd_queue
// run-length request queue: one entry per arrival minute with its count
// ----------------------------------------------------------------------------
module trd_queue
  import trd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [CNT_W-1:0]   push_cnt,
  input  logic [TIME_W-1:0]  push_minute,
  input  logic               pop,
  output logic [TIME_W-1:0]  head_minute,
  output logic               nonempty,
  output logic               ovf,
  output logic [QLEN_W-1:0]  queued
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UW = $clog2(DEPTH + 1);
  localparam int TW = $clog2(DEPTH * 255 + 1);

  logic [AW-1:0]    head;
  logic [UW-1:0]    used;
  logic [TW-1:0]    total;
  logic [CNT_W-1:0] taken;
  logic [UW:0]      tail_sum;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    head_inc;
  logic [ENTRY_W-1:0] rdata;
  logic             full;
  logic             wr;

  assign full     = (used == UW'(DEPTH));
  assign wr       = push && (push_cnt != '0) && !full;
  assign ovf      = push && (push_cnt != '0) && full;
  assign tail_sum = (UW+1)'(head) + (UW+1)'(used);
  assign tail     = (tail_sum >= (UW+1)'(DEPTH)) ? AW'(tail_sum - (UW+1)'(DEPTH))
                                                 : AW'(tail_sum);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign nonempty = (used != '0);
  assign head_minute = rdata[ENTRY_W-1:CNT_W];
  assign queued   = (int'(total) > int'(QLEN_SAT)) ? QLEN_SAT : QLEN_W'(total);

  trd_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (tail),
    .wdata ({push_minute, push_cnt}),
    .raddr (head),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      used  <= '0;
      total <= '0;
      taken <= '0;
    end else if (wr) begin
      used  <= used + 1'b1;
      total <= total + TW'(push_cnt);
    end else if (pop) begin
      total <= total - 1'b1;
      // head entry drained: move on to the next arrival minute
      if (taken + 1'b1 == rdata[CNT_W-1:0]) begin
        head  <= head_inc;
        used  <= used - 1'b1;
        taken <= '0;
      end else begin
        taken <= taken + 1'b1;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(DEPTH)) else $error("queue fill count beyond depth");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (used == '0) |-> (total == '0)) else $error("empty queue with requests");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty) else $error("pop from empty queue");

endmodule

/* rtl/trd_ctrl.sv */
// ----------------------------------------------------------------------------
// trd_ctrl
// tick sequencer: push, assignment scan, emission, marker, release scan
// ----------------------------------------------------------------------------
module trd_ctrl
  import trd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ARD   = 9'b000000010,
    S_ADO   = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_ERD   = 9'b000010000,
    S_EOUT  = 9'b000100000,
    S_MARK  = 9'b001000000,
    S_REL   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd        = CMD_PUSH;
          state_next = S_ARD;
        end
      end
      S_ARD: begin
        state_next = stat.scan_none ? S_CHECK : S_ADO;
      end
      S_ADO: begin
        cmd        = CMD_ASSIGN;
        state_next = stat.scan_last ? S_CHECK : S_ARD;
      end
      S_CHECK: begin
        cmd        = CMD_CHECK;
        state_next = stat.rec_none ? S_MARK : S_ERD;
      end
      S_ERD: begin
        state_next = S_EOUT;
      end
      S_EOUT: begin
        cmd        = CMD_EMIT;
        state_next = stat.rec_last ? S_MARK : S_ERD;
      end
      S_MARK: begin
        cmd        = CMD_MARK;
        state_next = stat.scan_none ? S_DONE : S_REL;
      end
      S_REL: begin
        cmd        = CMD_RELEASE;
        state_next = stat.scan_last ? S_DONE : S_REL;
      end
      S_DONE: begin
        cmd        = CMD_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_start_push: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_ARD)) else $error("accepted tick not started");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> !busy) else $error("tick did not end");

  a_emit_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EOUT) |-> $past(state == S_ERD)) else $error("record used before read");

endmodule

/* rtl/trd_datapath.sv */
// ----------------------------------------------------------------------------
// trd_datapath
// queues, runway timers, counters, record buffer and result registers
// ----------------------------------------------------------------------------
module trd_datapath
  import trd_pkg::*;
#(
  parameter int SERVERS     = SERVERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              stat,
  input  logic [CNT_W-1:0]     land_arrivals,
  input  logic [CNT_W-1:0]     takeoff_arrivals,
  input  logic                 stop_arrivals,
  input  logic                 cfg_we,
  input  logic [CFG_IX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 strobe,
  output logic [1:0]           event_kind,
  output logic [ID_W-1:0]      plane_id,
  output logic [SRV_W-1:0]     server_index,
  output logic [TIME_W-1:0]    minute,
  output logic [TIME_W-1:0]    wait_minutes,
  output logic [QLEN_W-1:0]    land_queued,
  output logic [QLEN_W-1:0]    takeoff_queued,
  output logic [TOTAL_W-1:0]   land_wait_total,
  output logic [TOTAL_W-1:0]   takeoff_wait_total,
  output logic                 overflow,
  output logic                 finished,
  output logic                 last
);

  localparam int SW    = $clog2(SERVERS + 1);
  localparam int SIW   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int RDEP  = (SERVERS < 2) ? 2 : SERVERS;
  localparam int RAW   = $clog2(RDEP);

  // configuration
  logic [ACT_W-1:0] active_servers;
  logic [CNT_W-1:0] land_time, to_time;
  logic [ID_W-1:0]  land_base, to_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_servers <= ACTIVE_RST;
      land_time      <= SVC_TIME_RST;
      to_time        <= SVC_TIME_RST;
      land_base      <= LAND_ID_RST;
      to_base        <= TO_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE:    active_servers <= cfg_data[ACT_W-1:0];
        REG_LAND_TIME: land_time      <= cfg_data[CNT_W-1:0];
        REG_TO_TIME:   to_time        <= cfg_data[CNT_W-1:0];
        REG_LAND_ID:   land_base      <= cfg_data;
        REG_TO_ID:     to_base        <= cfg_data;
        default: ;
      endcase
    end
  end

  // state
  logic [TIME_W-1:0]  minute_cnt;
  logic [CNT_W-1:0]   rem [SERVERS];
  logic [ID_W-1:0]    land_served, to_served;
  logic [TOTAL_W-1:0] land_total, to_total;
  logic               stopped, ovf_tick, fin_tick, have_rel;
  logic [SW-1:0]      scan, last_rel, rec_cnt;
  logic [RAW-1:0]     rec_ptr;

  logic [SW-1:0]      n_srv;
  logic [SIW-1:0]     idx;
  logic               stop_now, push_en;
  logic               land_ne, to_ne, land_ovf, to_ovf;
  logic [TIME_W-1:0]  land_min, to_min;
  logic [QLEN_W-1:0]  land_q, to_q;
  logic               free, take_land, take_to, land_pop, to_pop;
  logic [TIME_W-1:0]  wait_w;
  logic [ID_W-1:0]    id_w;
  logic [REC_W-1:0]   rec_wdata, rec_rdata;
  logic               fin_c, have_rel_c;
  logic [SW-1:0]      last_rel_c;
  logic [TOTAL_W:0]   land_sum, to_sum;

  assign n_srv    = (int'(active_servers) > SERVERS) ? SW'(SERVERS) : SW'(active_servers);
  assign idx      = SIW'(scan - 1'b1);
  assign stop_now = stopped | stop_arrivals;
  assign push_en  = (cmd == CMD_PUSH) && !stop_now;

  assign free      = (rem[idx] == '0);
  assign take_land = (cmd == CMD_ASSIGN) && free && land_ne;
  assign take_to   = (cmd == CMD_ASSIGN) && free && !land_ne && to_ne;
  assign land_pop  = take_land;
  assign to_pop    = take_to;
  assign wait_w    = minute_cnt - (take_land ? land_min : to_min);
  assign id_w      = take_land ? land_base + land_served : to_base + to_served;
  assign rec_wdata = {take_to, id_w, SRV_W'(scan), wait_w};
  assign land_sum  = {1'b0, land_total} + (TOTAL_W+1)'(wait_w);
  assign to_sum    = {1'b0, to_total} + (TOTAL_W+1)'(wait_w);

  assign stat.scan_none = (n_srv == '0);
  assign stat.scan_last = (scan == n_srv);
  assign stat.rec_none  = (rec_cnt == '0);
  assign stat.rec_last  = (SW'(rec_ptr) + 1'b1 == rec_cnt);

  trd_queue #(.DEPTH(QUEUE_DEPTH)) u_land_q (
    .clk(clk), .rst(rst), .push(push_en), .push_cnt(land_arrivals),
    .push_minute(minute_cnt), .pop(land_pop), .head_minute(land_min),
    .nonempty(land_ne), .ovf(land_ovf), .queued(land_q)
  );

  trd_queue #(.DEPTH(QUEUE_DEPTH)) u_to_q (
    .clk(clk), .rst(rst), .push(push_en), .push_cnt(takeoff_arrivals),
    .push_minute(minute_cnt), .pop(to_pop), .head_minute(to_min),
    .nonempty(to_ne), .ovf(to_ovf), .queued(to_q)
  );

  trd_ram #(.WIDTH(REC_W), .DEPTH(RDEP)) u_rec (
    .clk   (clk),
    .we    (take_land || take_to),
    .waddr (rec_cnt[RAW-1:0]),
    .wdata (rec_wdata),
    .raddr (rec_ptr),
    .rdata (rec_rdata)
  );

  // finish test and last releasing runway, taken after the assignments
  always_comb begin
    fin_c      = stopped && !land_ne && !to_ne;
    have_rel_c = 1'b0;
    last_rel_c = '0;
    for (int k = 0; k < SERVERS; k++) begin
      if (k < int'(n_srv)) begin
        if (rem[k] > CNT_W'(1)) begin
          fin_c = 1'b0;
        end
        if (rem[k] == CNT_W'(1)) begin
          have_rel_c = 1'b1;
          last_rel_c = SW'(k + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_cnt  <= MINUTE_RST;
      land_served <= '0;
      to_served   <= '0;
      land_total  <= '0;
      to_total    <= '0;
      stopped     <= 1'b0;
      scan        <= '0;
      rec_cnt     <= '0;
      rec_ptr     <= '0;
      strobe      <= 1'b0;
      for (int k = 0; k < SERVERS; k++) begin
        rem[k] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      case (cmd)
        CMD_PUSH: begin
          stopped  <= stop_now;
          ovf_tick <= land_ovf | to_ovf;
          scan     <= SW'(1);
          rec_cnt  <= '0;
        end
        CMD_ASSIGN: begin
          scan <= scan + 1'b1;
          if (take_land) begin
            rem[idx]    <= land_time;
            land_served <= land_served + 1'b1;
            land_total  <= land_sum[TOTAL_W] ? '1 : land_sum[TOTAL_W-1:0];
            rec_cnt     <= rec_cnt + 1'b1;
          end else if (take_to) begin
            rem[idx]  <= to_time;
            to_served <= to_served + 1'b1;
            to_total  <= to_sum[TOTAL_W] ? '1 : to_sum[TOTAL_W-1:0];
            rec_cnt   <= rec_cnt + 1'b1;
          end
        end
        CMD_CHECK: begin
          fin_tick <= fin_c;
          have_rel <= have_rel_c;
          last_rel <= last_rel_c;
          rec_ptr  <= '0;
        end
        CMD_EMIT: begin
          rec_ptr <= rec_ptr + 1'b1;
          strobe  <= 1'b1;
        end
        CMD_MARK: begin
          scan   <= SW'(1);
          strobe <= 1'b1;
        end
        CMD_RELEASE: begin
          scan <= scan + 1'b1;
          if (!free) begin
            rem[idx] <= rem[idx] - 1'b1;
            strobe   <= (rem[idx] == CNT_W'(1));
          end
        end
        CMD_DONE: begin
          minute_cnt <= minute_cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_EMIT: begin
        event_kind         <= rec_rdata[REC_W-1] ? EV_TAKEOFF : EV_LAND;
        plane_id           <= rec_rdata[REC_W-2 -: ID_W];
        server_index       <= rec_rdata[TIME_W +: SRV_W];
        wait_minutes       <= rec_rdata[TIME_W-1:0];
        land_queued        <= '0;
        takeoff_queued     <= '0;
        land_wait_total    <= '0;
        takeoff_wait_total <= '0;
        last               <= 1'b0;
      end
      CMD_MARK: begin
        event_kind         <= EV_MARKER;
        plane_id           <= '0;
        server_index       <= '0;
        wait_minutes       <= '0;
        land_queued        <= land_q;
        takeoff_queued     <= to_q;
        land_wait_total    <= land_total;
        takeoff_wait_total <= to_total;
        last               <= !have_rel;
      end
      CMD_RELEASE: begin
        event_kind         <= EV_FREED;
        plane_id           <= '0;
        server_index       <= SRV_W'(scan);
        wait_minutes       <= '0;
        land_queued        <= '0;
        takeoff_queued     <= '0;
        land_wait_total    <= '0;
        takeoff_wait_total <= '0;
        last               <= (scan == last_rel);
      end
      default: ;
    endcase
    minute   <= minute_cnt;
    overflow <= ovf_tick;
    finished <= fin_tick;
  end

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe) else $error("result after final result");

  a_one_pop: assert property (@(posedge clk) disable iff (rst)
    !(land_pop && to_pop)) else $error("two requests taken by one runway");

  a_rec_bound: assert property (@(posedge clk) disable iff (rst)
    rec_cnt <= n_srv || cmd == CMD_NONE || cmd == CMD_PUSH)
    else $error("more assignments than runways");

endmodule

/* rtl/two_class_runway_dispatcher_top.sv */
// ----------------------------------------------------------------------------
// two_class_runway_dispatcher_top
// strict-priority runway dispatcher stepped once per minute tick
// ----------------------------------------------------------------------------
// a tick is accepted when start is high and busy is low. busy then stays high
// until every result of the tick has been shown, so one tick is worked at a
// time. results appear one per strobe cycle and cannot be held off: first the
// landing/takeoff assignments, then the minute marker, then the runway-freed
// events; last marks the final result of the tick. the assignment scan
// visits each runway in a read state and an assign state, because each
// queue pop waits on the registered read of the queue ram, and each
// assignment is replayed from a small record ram through a read state and
// an emit state so that overflow and finished, known only after the scan,
// ride on every result.
// configuration writes are taken at any cycle but should only be issued
// while busy is low. queue contents are not cleared at reset; the fill
// counts make stale entries unreachable.
// ----------------------------------------------------------------------------
module two_class_runway_dispatcher_top
  import trd_pkg::*;
#(
  parameter int SERVERS     = SERVERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // tick transaction
  input  logic                start,
  output logic                busy,
  input  logic [CNT_W-1:0]    land_arrivals,
  input  logic [CNT_W-1:0]    takeoff_arrivals,
  input  logic                stop_arrivals,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // result transactions
  output logic                strobe,
  output logic [1:0]          event_kind,
  output logic [ID_W-1:0]     plane_id,
  output logic [SRV_W-1:0]    server_index,
  output logic [TIME_W-1:0]   minute,
  output logic [TIME_W-1:0]   wait_minutes,
  output logic [QLEN_W-1:0]   land_queued,
  output logic [QLEN_W-1:0]   takeoff_queued,
  output logic [TOTAL_W-1:0]  land_wait_total,
  output logic [TOTAL_W-1:0]  takeoff_wait_total,
  output logic                overflow,
  output logic                finished,
  output logic                last
);

  cmd_t    cmd;   // one command per cycle from the sequencer
  status_t stat;  // scan and record-buffer position flags

  // sequencer: walks push, assign scan, replay, marker, release scan
  trd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: queues, runway timers, totals and result registers
  trd_datapath #(
    .SERVERS     (SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .land_arrivals      (land_arrivals),
    .takeoff_arrivals   (takeoff_arrivals),
    .stop_arrivals      (stop_arrivals),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .strobe             (strobe),
    .event_kind         (event_kind),
    .plane_id           (plane_id),
    .server_index       (server_index),
    .minute             (minute),
    .wait_minutes       (wait_minutes),
    .land_queued        (land_queued),
    .takeoff_queued     (takeoff_queued),
    .land_wait_total    (land_wait_total),
    .takeoff_wait_total (takeoff_wait_total),
    .overflow           (overflow),
    .finished           (finished),
    .last               (last)
  );

endmodule

/* verif/two_class_runway_dispatcher_top_tb.sv */
// ----------------------------------------------------------------------------
// two_class_runway_dispatcher_top_tb
// self-checking bench for the runway dispatcher: a behavioral copy of the
// dispatcher predicts every assignment, marker and release per minute tick,
// and a monitor compares each strobed result with the oldest prediction
// ----------------------------------------------------------------------------
module two_class_runway_dispatcher_top_tb;
  import trd_pkg::*;

  localparam int NRUN      = 8;
  localparam int QDEPTH    = 64;
  localparam int RAND_TICKS = 270;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE    = 60;

  // one result transaction as seen on the ports
  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_W-1:0]    id;
    logic [SRV_W-1:0]   srv;
    logic [TIME_W-1:0]  mnt;
    logic [TIME_W-1:0]  waited;
    logic [QLEN_W-1:0]  lq;
    logic [QLEN_W-1:0]  tq;
    logic [TOTAL_W-1:0] lwt;
    logic [TOTAL_W-1:0] twt;
    logic               ovf;
    logic               fin;
    logic               lst;
  } dispatch_ev_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [CNT_W-1:0]    land_arrivals = '0;
  logic [CNT_W-1:0]    takeoff_arrivals = '0;
  logic                stop_arrivals = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                strobe;
  logic [1:0]          event_kind;
  logic [ID_W-1:0]     plane_id;
  logic [SRV_W-1:0]    server_index;
  logic [TIME_W-1:0]   minute;
  logic [TIME_W-1:0]   wait_minutes;
  logic [QLEN_W-1:0]   land_queued;
  logic [QLEN_W-1:0]   takeoff_queued;
  logic [TOTAL_W-1:0]  land_wait_total;
  logic [TOTAL_W-1:0]  takeoff_wait_total;
  logic                overflow;
  logic                finished;
  logic                last;

  two_class_runway_dispatcher_top uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // dispatcher shadow state: class 0 is landing, class 1 is takeoff
  // ---------------------------------------------------------------------------
  int unsigned        cur_minute;
  int unsigned        arr_minute [2][QDEPTH];
  int unsigned        arr_count  [2][QDEPTH];
  int unsigned        q_head [2];
  int unsigned        q_used [2];
  int unsigned        q_total [2];
  int unsigned        runway_left [1:NRUN];
  int unsigned        served [2];
  logic [TOTAL_W-1:0] wait_sum [2];
  bit                 arrivals_stopped;
  // shadow configuration
  int unsigned        n_active;
  int unsigned        svc_time [2];
  int unsigned        id_base [2];

  dispatch_ev_t pending_events[$];
  int           mismatches = 0;
  int           cycles = 0;

  // ---------------------------------------------------------------------------
  // prediction of one accepted minute tick
  // ---------------------------------------------------------------------------
  task automatic dispatch_tick(input int unsigned land_n, input int unsigned to_n,
                               input bit stop_in);
    dispatch_ev_t tick_ev[$];
    dispatch_ev_t ev;
    int unsigned  scan_n;
    int unsigned  counts [2];
    int unsigned  wt;
    int unsigned  arr_m;
    bit           ovf;
    bit           fin;
    int           cls;
    logic [32:0]  sum;
    scan_n = (n_active > NRUN) ? NRUN : n_active;
    counts[0] = land_n;
    counts[1] = to_n;
    ovf = 1'b0;
    fin = 1'b1;
    if (stop_in) arrivals_stopped = 1'b1;
    // enqueue, one run-length entry per class and minute
    if (!arrivals_stopped) begin
      for (int c = 0; c < 2; c++) begin
        if (counts[c] != 0) begin
          if (q_used[c] >= QDEPTH) begin
            ovf = 1'b1;
          end else begin
            arr_minute[c][(q_head[c] + q_used[c]) % QDEPTH] = cur_minute;
            arr_count[c][(q_head[c] + q_used[c]) % QDEPTH]  = counts[c];
            q_used[c]++;
            q_total[c] += counts[c];
          end
        end
      end
    end
    // assignment scan, landings take strict priority
    for (int r = 1; r <= scan_n; r++) begin
      if (runway_left[r] != 0) continue;
      if (q_used[0] != 0) cls = 0;
      else if (q_used[1] != 0) cls = 1;
      else continue;
      arr_m = arr_minute[cls][q_head[cls]];
      arr_count[cls][q_head[cls]]--;
      if (arr_count[cls][q_head[cls]] == 0) begin
        q_head[cls] = (q_head[cls] + 1) % QDEPTH;
        q_used[cls]--;
      end
      q_total[cls]--;
      wt = (cur_minute - arr_m) & 16'hFFFF;
      runway_left[r] = svc_time[cls];
      ev = '0;
      ev.kind   = (cls == 0) ? EV_LAND : EV_TAKEOFF;
      ev.id     = ID_W'(id_base[cls] + served[cls]);
      ev.srv    = SRV_W'(r);
      ev.mnt    = TIME_W'(cur_minute);
      ev.waited = TIME_W'(wt);
      tick_ev.push_back(ev);
      served[cls] = (served[cls] + 1) & 16'hFFFF;
      sum = {1'b0, wait_sum[cls]} + 33'(wt);
      wait_sum[cls] = sum[32] ? '1 : sum[31:0];
    end
    // minute marker
    ev = '0;
    ev.kind = EV_MARKER;
    ev.mnt  = TIME_W'(cur_minute);
    ev.lq   = (q_total[0] > QLEN_SAT) ? QLEN_SAT : QLEN_W'(q_total[0]);
    ev.tq   = (q_total[1] > QLEN_SAT) ? QLEN_SAT : QLEN_W'(q_total[1]);
    ev.lwt  = wait_sum[0];
    ev.twt  = wait_sum[1];
    tick_ev.push_back(ev);
    // releases
    for (int r = 1; r <= scan_n; r++) begin
      if (runway_left[r] == 0) continue;
      runway_left[r]--;
      if (runway_left[r] == 0) begin
        ev = '0;
        ev.kind = EV_FREED;
        ev.srv  = SRV_W'(r);
        ev.mnt  = TIME_W'(cur_minute);
        tick_ev.push_back(ev);
      end else begin
        fin = 1'b0;
      end
    end
    cur_minute = (cur_minute + 1) & 16'hFFFF;
    fin = fin && arrivals_stopped && q_used[0] == 0 && q_used[1] == 0;
    foreach (tick_ev[k]) begin
      tick_ev[k].ovf = ovf;
      tick_ev[k].fin = fin;
      tick_ev[k].lst = (k == tick_ev.size() - 1);
      pending_events.push_back(tick_ev[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result monitor: every strobe is one transaction, no backpressure exists
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dispatch_ev_t seen;
    dispatch_ev_t want;
    if (!rst && strobe) begin
      seen = '{event_kind, plane_id, server_index, minute, wait_minutes, land_queued,
               takeoff_queued, land_wait_total, takeoff_wait_total, overflow,
               finished, last};
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", seen);
      end else begin
        want = pending_events.pop_front();
        if (seen.kind !== want.kind || seen.id !== want.id || seen.srv !== want.srv ||
            seen.mnt !== want.mnt || seen.waited !== want.waited ||
            seen.lq !== want.lq || seen.tq !== want.tq || seen.lwt !== want.lwt ||
            seen.twt !== want.twt || seen.ovf !== want.ovf ||
            seen.fin !== want.fin || seen.lst !== want.lst) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %p", want);
            $display("  actual   %p", seen);
          end
        end
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // idle gap: mostly back to back or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one tick transaction; start stays high when the next one follows at once
  task automatic send_tick(input int unsigned land_n, input int unsigned to_n,
                           input bit stop_in, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    land_arrivals    <= CNT_W'(land_n);
    takeoff_arrivals <= CNT_W'(to_n);
    stop_arrivals    <= stop_in;
    do @(posedge clk); while (busy);
    dispatch_tick(land_n, to_n, stop_in);
  endtask

  // drain all expected results and let the block settle
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ACTIVE:    n_active    = value & 4'hF;
      REG_LAND_TIME: svc_time[0] = value & 8'hFF;
      REG_TO_TIME:   svc_time[1] = value & 8'hFF;
      REG_LAND_ID:   id_base[0]  = value & 16'hFFFF;
      REG_TO_ID:     id_base[1]  = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned act, input int unsigned lt,
                           input int unsigned tt, input int unsigned lid,
                           input int unsigned tid);
    wait_quiet();
    write_reg(REG_ACTIVE, act);
    write_reg(REG_LAND_TIME, lt);
    write_reg(REG_TO_TIME, tt);
    write_reg(REG_LAND_ID, lid);
    write_reg(REG_TO_ID, tid);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset values, field extremes, id wrap, zero service time
  task automatic test_extremes();
    send_tick(0, 0, 0, 0);
    send_tick(1, 1, 0, 0);
    send_tick(255, 0, 0, 2);
    send_tick(0, 255, 0, 0);
    configure(8, 0, 0, 16'hFFFF, 16'hFFFE);
    send_tick(3, 5, 0, 0);
    send_tick(170, 85, 0, 0);
    send_tick(85, 170, 0, 1);
    configure(15, 255, 1, 0, 16'hFFFF);
    send_tick(2, 9, 0, 0);
    send_tick(0, 0, 0, 0);
  endtask

  // no runway scanned lets the queues fill until arrivals are dropped
  task automatic test_overflow();
    configure(0, 1, 1, 100, 200);
    for (int t = 0; t < 70; t++) send_tick(1, (t % 3 == 0) ? 0 : 1, 0, pick_gap());
    configure(8, 0, 0, 300, 400);
    for (int t = 0; t < 20; t++) send_tick(0, 0, 0, pick_gap());
  endtask

  // busy runways above the active count keep their time and are skipped
  task automatic test_deactivated();
    configure(8, 6, 4, 1000, 2000);
    send_tick(4, 6, 0, 0);
    configure(2, 6, 4, 1000, 2000);
    for (int t = 0; t < 4; t++) send_tick(1, 1, 0, 0);
    configure(8, 2, 3, 1000, 2000);
    for (int t = 0; t < 8; t++) send_tick(0, 0, 0, pick_gap());
  endtask

  // random phases with random settings and mostly light traffic
  task automatic test_random();
    int unsigned ln;
    int unsigned tn;
    int unsigned p;
    for (int ph = 0; ph < 6; ph++) begin
      configure($urandom_range(0, 15),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
      for (int t = 0; t < RAND_TICKS / 6; t++) begin
        p = $urandom_range(0, 99);
        if (p < 70) begin
          ln = $urandom_range(0, 3);
          tn = $urandom_range(0, 3);
        end else if (p < 85) begin
          ln = 0;
          tn = 0;
        end else begin
          ln = $urandom_range(0, 255);
          tn = $urandom_range(0, 255);
        end
        send_tick(ln, tn, 0, pick_gap());
      end
    end
  endtask

  // stop is sticky, so this runs last: counts ignored, queues drain to finished
  task automatic test_stop();
    configure(8, 1, 2, 7, 9);
    send_tick(5, 7, 0, 0);
    send_tick(255, 255, 1, 0);
    for (int t = 0; t < 60; t++)
      send_tick($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                pick_gap());
    configure(0, 3, 3, 0, 0);
    send_tick(1, 1, 0, 0);
  endtask

  initial begin
    cur_minute = 1;
    foreach (q_head[c]) begin
      q_head[c]  = 0;
      q_used[c]  = 0;
      q_total[c] = 0;
      served[c]  = 0;
      wait_sum[c] = '0;
    end
    foreach (runway_left[r]) runway_left[r] = 0;
    arrivals_stopped = 1'b0;
    n_active    = ACTIVE_RST;
    svc_time[0] = SVC_TIME_RST;
    svc_time[1] = SVC_TIME_RST;
    id_base[0]  = LAND_ID_RST;
    id_base[1]  = TO_ID_RST;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_overflow();
    test_deactivated();
    test_random();
    test_stop();

    wait_quiet();
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
